// ----- rtl/core/aaf_pkg.sv -----
// Shared constants, types and elaboration-time table functions for the
// aero angle pipeline (CORDIC arctangent table, CORDIC gain).
// No dependencies.
package aaf_pkg;

   localparam int CORDIC_STEPS_DEF = 24;
   localparam int VEL_WIDTH_DEF    = 32;

   localparam int THR_W    = 31;          // speed threshold register
   localparam int NORM_W   = 58;          // normalized magnitudes, msb at bit 57
   localparam int AFRAC    = 61;          // angle fraction bits inside the pipe
   localparam int GFRAC    = 30;          // gain fraction bits
   localparam int GAIN_W   = 31;
   localparam int XW       = 63;          // signed CORDIC x/y datapath
   localparam int ZW       = 64;          // signed angle accumulator
   localparam int DIV_W    = 62;          // residual divider remainder/divisor
   localparam int ATT_W    = 31;
   localparam int SIDE_W   = 30;
   localparam int ROUND_SH = AFRAC - 28;  // output LSB is 2^-28 rad
   localparam int RSP_W    = 64;

   typedef struct packed {
      logic [NORM_W-1:0] a;      // first magnitude term
      logic [NORM_W-1:0] b;      // second magnitude term
      logic [NORM_W-1:0] cm;     // magnitude of the opposite component
      logic              cneg;   // sign of the opposite component
      logic              guard;  // angle is computed, else forced to zero
   } aaf_vec_type;

   // restoring divide, elaboration only
   function automatic logic [63:0] udiv64(input logic [63:0] num, input logic [63:0] den);
      logic [63:0] q;
      logic [64:0] r;
      q = '0;
      r = '0;
      for (int i = 63; i >= 0; i--) begin
         r = {r[63:0], num[i]};
         if (r >= {1'b0, den}) begin
            r    = r - {1'b0, den};
            q[i] = 1'b1;
         end
      end
      return q;
   endfunction

   // atan(1/n) with AFRAC fraction bits, Taylor series, n >= 2
   function automatic logic [63:0] atan_recip(input logic [63:0] n);
      logic [63:0] p;
      logic [63:0] n2;
      logic [63:0] k;
      logic [63:0] t;
      logic [63:0] sum;
      p   = udiv64(64'd1 << AFRAC, n);
      n2  = n * n;
      k   = '0;
      sum = '0;
      for (int it = 0; it < 64; it++) begin
         if (p != 64'd0) begin
            t   = udiv64(p, (k << 1) + 64'd1);
            sum = k[0] ? sum - t : sum + t;
            p   = udiv64(p, n2);
            k   = k + 64'd1;
         end
      end
      return sum;
   endfunction

   function automatic logic [63:0] atan_entry(input int i);
      if (i == 0) begin
         return atan_recip(64'd2) + atan_recip(64'd3);
      end
      return atan_recip(64'd1 << i);
   endfunction

   function automatic logic [63:0] isqrt64(input logic [63:0] val);
      logic [63:0] v;
      logic [63:0] res;
      logic [63:0] b;
      v   = val;
      res = '0;
      b   = 64'd1 << 62;
      for (int i = 0; i < 32; i++) begin
         if (b > v) b = b >> 2;
      end
      for (int i = 0; i < 32; i++) begin
         if (b != 64'd0) begin
            if (v >= res + b) begin
               v   = v - (res + b);
               res = (res >> 1) + b;
            end else begin
               res = res >> 1;
            end
            b = b >> 2;
         end
      end
      return res;
   endfunction

   function automatic logic [63:0] cordic_gain(input int steps);
      logic [63:0] m;
      m = 64'd1 << 60;
      for (int i = 0; i < steps; i++) begin
         m = m + (m >> (2 * i));
      end
      return isqrt64(m);
   endfunction

endpackage

// ----- rtl/core/aero_angles_from_body_velocity.sv -----
// Angle of attack and sideslip from a body-axis velocity vector.
// Depends on aaf_pkg, aaf_prep, aaf_angle.
//
// req channel: one transfer carries vel_u, vel_v, vel_w (signed Q15.16 m/s).
// rsp channel: one transfer per request carries attack_angle and sideslip,
// signed radians with LSB 2^-28, in request order.
// csr: csr_wr_en writes csr_wr_data into the speed threshold (Q15.16 m/s);
// write it only while no request is in flight.
//
// The pipe holds the front end, the two unrolled CORDIC passes and the
// 61-stage residual divider.
// Throughput: one transfer per cycle on both sides while the receiver keeps up.
// All stages share one advance enable: the pipe moves whenever the output
// register is empty or being taken. When the receiver holds off with a
// result waiting, the whole pipe freezes and req_tready drops; nothing is
// lost or repeated.
// Reset clears all valid bits and sets the threshold to zero.
module aero_angles_from_body_velocity #(
   parameter int CORDIC_STEPS = aaf_pkg::CORDIC_STEPS_DEF,
   parameter int VEL_WIDTH    = aaf_pkg::VEL_WIDTH_DEF,
   localparam int REQ_W       = ((3 * VEL_WIDTH + 7) / 8) * 8
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [REQ_W-1:0]          req_tdata,   // vel_u, vel_v, vel_w, zero pad
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   output logic [aaf_pkg::RSP_W-1:0] rsp_tdata,   // attack_angle, sideslip, zero pad
   input  logic                      csr_wr_en,
   input  logic [aaf_pkg::THR_W-1:0] csr_wr_data
);
   import aaf_pkg::*;

   logic [THR_W-1:0] thr_ff;
   logic             en, pre_v, att_v, side_v;
   aaf_vec_type      att_vec, side_vec;
   logic [ATT_W-1:0]  att;
   logic [SIDE_W-1:0] side;

   always_ff @(posedge clock) begin
      if (reset) thr_ff <= '0;
      else if (csr_wr_en) thr_ff <= csr_wr_data;
   end

   assign en         = ~rsp_tvalid | rsp_tready;
   assign req_tready = en;

   aaf_prep #(.VEL_WIDTH(VEL_WIDTH)) u_prep (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (req_tvalid),
      .vel_u    (req_tdata[VEL_WIDTH-1:0]),
      .vel_v    (req_tdata[2*VEL_WIDTH-1:VEL_WIDTH]),
      .vel_w    (req_tdata[3*VEL_WIDTH-1:2*VEL_WIDTH]),
      .thr      (thr_ff),
      .out_valid(pre_v),
      .att_o    (att_vec),
      .side_o   (side_vec)
   );

   aaf_angle #(.STEPS(CORDIC_STEPS), .OUT_W(ATT_W)) u_att (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (pre_v),
      .vec_i    (att_vec),
      .out_valid(att_v),
      .angle_o  (att)
   );

   aaf_angle #(.STEPS(CORDIC_STEPS), .OUT_W(SIDE_W)) u_side (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (pre_v),
      .vec_i    (side_vec),
      .out_valid(side_v),
      .angle_o  (side)
   );

   // both lanes run in lockstep
   assign rsp_tvalid = att_v & side_v;
   assign rsp_tdata  = {{(RSP_W - ATT_W - SIDE_W){1'b0}}, side, att};

endmodule

// ----- rtl/core/aaf_prep.sv -----
// Front end: magnitudes, speed guards and normalizing shift (4 stages).
// Depends on aaf_pkg.
module aaf_prep #(
   parameter int VEL_WIDTH = aaf_pkg::VEL_WIDTH_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     in_valid,
   input  logic [VEL_WIDTH-1:0]     vel_u,
   input  logic [VEL_WIDTH-1:0]     vel_v,
   input  logic [VEL_WIDTH-1:0]     vel_w,
   input  logic [aaf_pkg::THR_W-1:0] thr,
   output logic                     out_valid,
   output aaf_pkg::aaf_vec_type     att_o,
   output aaf_pkg::aaf_vec_type     side_o
);
   import aaf_pkg::*;

   localparam int LO_W  = (VEL_WIDTH + 1) / 2;
   localparam int HI_W  = VEL_WIDTH - LO_W;
   localparam int TLO_W = 16;
   localparam int THI_W = THR_W - TLO_W;
   localparam int SQ_W  = 2 * VEL_WIDTH + 2;
   localparam int CMP_W = (VEL_WIDTH > THR_W) ? VEL_WIDTH : THR_W;

   // stage 1: magnitudes
   logic                 v1_ff;
   logic [VEL_WIDTH-1:0] mu1_ff, mv1_ff, mw1_ff;
   logic                 nv1_ff, nw1_ff;

   always_ff @(posedge clock) begin
      if (reset) v1_ff <= 1'b0;
      else if (en) v1_ff <= in_valid;
      if (en) begin
         mu1_ff <= vel_u[VEL_WIDTH-1] ? ~vel_u + 1'b1 : vel_u;
         mv1_ff <= vel_v[VEL_WIDTH-1] ? ~vel_v + 1'b1 : vel_v;
         mw1_ff <= vel_w[VEL_WIDTH-1] ? ~vel_w + 1'b1 : vel_w;
         nv1_ff <= vel_v[VEL_WIDTH-1];
         nw1_ff <= vel_w[VEL_WIDTH-1];
      end
   end

   // stage 2: partial products of the squares, threshold compares, max
   logic                     v2_ff;
   logic [VEL_WIDTH-1:0]     mu2_ff, mv2_ff, mw2_ff, mx2_ff, mx_in;
   logic                     nv2_ff, nw2_ff, gu2_ff, gv2_ff, gw2_ff;
   logic [2*HI_W-1:0]        uhh_ff, vhh_ff;
   logic [HI_W+LO_W-1:0]     uhl_ff, vhl_ff;
   logic [2*LO_W-1:0]        ull_ff, vll_ff;
   logic [2*THI_W-1:0]       thh_ff;
   logic [THI_W+TLO_W-1:0]   thl_ff;
   logic [2*TLO_W-1:0]       tll_ff;

   always_comb begin
      mx_in = (mu1_ff > mv1_ff) ? mu1_ff : mv1_ff;
      if (mw1_ff > mx_in) mx_in = mw1_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) v2_ff <= 1'b0;
      else if (en) v2_ff <= v1_ff;
      if (en) begin
         mu2_ff <= mu1_ff;
         mv2_ff <= mv1_ff;
         mw2_ff <= mw1_ff;
         mx2_ff <= mx_in;
         nv2_ff <= nv1_ff;
         nw2_ff <= nw1_ff;
         gu2_ff <= CMP_W'(mu1_ff) > CMP_W'(thr);
         gv2_ff <= CMP_W'(mv1_ff) > CMP_W'(thr);
         gw2_ff <= CMP_W'(mw1_ff) > CMP_W'(thr);
         uhh_ff <= mu1_ff[VEL_WIDTH-1:LO_W] * mu1_ff[VEL_WIDTH-1:LO_W];
         uhl_ff <= mu1_ff[VEL_WIDTH-1:LO_W] * mu1_ff[LO_W-1:0];
         ull_ff <= mu1_ff[LO_W-1:0] * mu1_ff[LO_W-1:0];
         vhh_ff <= mv1_ff[VEL_WIDTH-1:LO_W] * mv1_ff[VEL_WIDTH-1:LO_W];
         vhl_ff <= mv1_ff[VEL_WIDTH-1:LO_W] * mv1_ff[LO_W-1:0];
         vll_ff <= mv1_ff[LO_W-1:0] * mv1_ff[LO_W-1:0];
         thh_ff <= thr[THR_W-1:TLO_W] * thr[THR_W-1:TLO_W];
         thl_ff <= thr[THR_W-1:TLO_W] * thr[TLO_W-1:0];
         tll_ff <= thr[TLO_W-1:0] * thr[TLO_W-1:0];
      end
   end

   // stage 3: guards, coarse normalize (32, 16, 8)
   logic [SQ_W-1:0]   usq, vsq, ssum;
   logic [63:0]       s64, tsq;
   logic              ga_in;
   logic [NORM_W-1:0] mx3_in, u3_in, v3_in, w3_in;
   logic              v3_ff, nv3_ff, nw3_ff, ga3_ff, gs3_ff;
   logic [NORM_W-1:0] mx3_ff, u3_ff, v3d_ff, w3_ff;

   always_comb begin
      usq  = (SQ_W'(uhh_ff) << (2 * LO_W)) + (SQ_W'(uhl_ff) << (LO_W + 1)) + SQ_W'(ull_ff);
      vsq  = (SQ_W'(vhh_ff) << (2 * LO_W)) + (SQ_W'(vhl_ff) << (LO_W + 1)) + SQ_W'(vll_ff);
      ssum = usq + vsq;
      s64  = 64'(ssum);   // 64-bit wrap, as the square sum is defined
      tsq  = (64'(thh_ff) << (2 * TLO_W)) + (64'(thl_ff) << (TLO_W + 1)) + 64'(tll_ff);
      ga_in = gu2_ff | gv2_ff | gw2_ff | (s64 > tsq);
      mx3_in = NORM_W'(mx2_ff);
      u3_in  = NORM_W'(mu2_ff);
      v3_in  = NORM_W'(mv2_ff);
      w3_in  = NORM_W'(mw2_ff);
      for (int j = 0; j < 3; j++) begin
         if ((mx3_in >> (NORM_W - (32 >> j))) == '0) begin
            mx3_in = mx3_in << (32 >> j);
            u3_in  = u3_in << (32 >> j);
            v3_in  = v3_in << (32 >> j);
            w3_in  = w3_in << (32 >> j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v3_ff <= 1'b0;
      else if (en) v3_ff <= v2_ff;
      if (en) begin
         mx3_ff <= mx3_in;
         u3_ff  <= u3_in;
         v3d_ff <= v3_in;
         w3_ff  <= w3_in;
         nv3_ff <= nv2_ff;
         nw3_ff <= nw2_ff;
         ga3_ff <= ga_in;
         gs3_ff <= gu2_ff | gv2_ff;
      end
   end

   // stage 4: fine normalize (4, 2, 1)
   logic [NORM_W-1:0] mx4_in, u4_in, v4_in, w4_in;
   logic              v4_ff;
   aaf_vec_type       att_ff, side_ff;

   always_comb begin
      mx4_in = mx3_ff;
      u4_in  = u3_ff;
      v4_in  = v3d_ff;
      w4_in  = w3_ff;
      for (int j = 0; j < 3; j++) begin
         if ((mx4_in >> (NORM_W - (4 >> j))) == '0) begin
            mx4_in = mx4_in << (4 >> j);
            u4_in  = u4_in << (4 >> j);
            v4_in  = v4_in << (4 >> j);
            w4_in  = w4_in << (4 >> j);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v4_ff <= 1'b0;
      else if (en) v4_ff <= v3_ff;
      if (en) begin
         att_ff  <= '{a: u4_in, b: v4_in, cm: w4_in, cneg: nw3_ff, guard: ga3_ff};
         side_ff <= '{a: u4_in, b: w4_in, cm: v4_in, cneg: nv3_ff, guard: gs3_ff};
      end
   end

   assign out_valid = v4_ff;
   assign att_o     = att_ff;
   assign side_o    = side_ff;

endmodule

// ----- rtl/core/aaf_cordic.sv -----
// One vectoring CORDIC pass, one micro-rotation per register stage.
// Depends on aaf_pkg (arctangent table, datapath widths).
module aaf_cordic #(
   parameter int STEPS = aaf_pkg::CORDIC_STEPS_DEF,
   parameter int PAY_W = 1
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           en,
   input  logic                           in_valid,
   input  logic signed [aaf_pkg::XW-1:0]  x_i,
   input  logic signed [aaf_pkg::XW-1:0]  y_i,
   input  logic signed [aaf_pkg::ZW-1:0]  z_i,
   input  logic [PAY_W-1:0]               pay_i,
   output logic                           out_valid,
   output logic signed [aaf_pkg::XW-1:0]  x_o,
   output logic signed [aaf_pkg::XW-1:0]  y_o,
   output logic signed [aaf_pkg::ZW-1:0]  z_o,
   output logic [PAY_W-1:0]               pay_o
);
   import aaf_pkg::*;

   logic                 v_ff   [STEPS];
   logic signed [XW-1:0] x_ff   [STEPS];
   logic signed [XW-1:0] y_ff   [STEPS];
   logic signed [ZW-1:0] z_ff   [STEPS];
   logic [PAY_W-1:0]     pay_ff [STEPS];

   for (genvar i = 0; i < STEPS; i++) begin : g_step
      localparam logic signed [ZW-1:0] ANGLE = ZW'(atan_entry(i));
      logic                 v_src;
      logic signed [XW-1:0] x_src, y_src, x_in, y_in;
      logic signed [ZW-1:0] z_src, z_in;
      logic [PAY_W-1:0]     pay_src;

      if (i == 0) begin : g_first
         assign v_src   = in_valid;
         assign x_src   = x_i;
         assign y_src   = y_i;
         assign z_src   = z_i;
         assign pay_src = pay_i;
      end else begin : g_next
         assign v_src   = v_ff[i-1];
         assign x_src   = x_ff[i-1];
         assign y_src   = y_ff[i-1];
         assign z_src   = z_ff[i-1];
         assign pay_src = pay_ff[i-1];
      end

      // rotate toward y = 0
      always_comb begin
         if (y_src >= 0) begin
            x_in = x_src + (y_src >>> i);
            y_in = y_src - (x_src >>> i);
            z_in = z_src + ANGLE;
         end else begin
            x_in = x_src - (y_src >>> i);
            y_in = y_src + (x_src >>> i);
            z_in = z_src - ANGLE;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) v_ff[i] <= 1'b0;
         else if (en) v_ff[i] <= v_src;
         if (en) begin
            x_ff[i]   <= x_in;
            y_ff[i]   <= y_in;
            z_ff[i]   <= z_in;
            pay_ff[i] <= pay_src;
         end
      end
   end

   assign out_valid = v_ff[STEPS-1];
   assign x_o       = x_ff[STEPS-1];
   assign y_o       = y_ff[STEPS-1];
   assign z_o       = z_ff[STEPS-1];
   assign pay_o     = pay_ff[STEPS-1];

endmodule

// ----- rtl/core/aaf_recip_div.sv -----
// Residual term y/x by a pipelined restoring divider (one quotient bit per
// stage), added to the CORDIC angle and rounded. Depends on aaf_pkg.
module aaf_recip_div #(
   parameter int OUT_W = aaf_pkg::ATT_W
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          en,
   input  logic                          in_valid,
   input  logic signed [aaf_pkg::XW-1:0] x_i,
   input  logic signed [aaf_pkg::XW-1:0] y_i,
   input  logic signed [aaf_pkg::ZW-1:0] z_i,
   input  logic                          guard_i,
   output logic                          out_valid,
   output logic [OUT_W-1:0]              angle_o
);
   import aaf_pkg::*;

   localparam logic signed [ZW-1:0] HALF = 64'sd1 <<< (ROUND_SH - 1);

   // setup: |y| clipped below x
   logic [XW-1:0]    ay;
   logic [DIV_W-1:0] xu_in, rem0_in;
   logic             v0_ff, xpos0_ff, yneg0_ff, guard0_ff;
   logic [DIV_W-1:0] xu0_ff, rem0_ff;
   logic signed [ZW-1:0] z0_ff;

   always_comb begin
      ay      = y_i[XW-1] ? XW'(-y_i) : XW'(y_i);
      xu_in   = DIV_W'(x_i);
      rem0_in = (ay < XW'(xu_in)) ? DIV_W'(ay) : xu_in - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) v0_ff <= 1'b0;
      else if (en) v0_ff <= in_valid;
      if (en) begin
         xpos0_ff  <= x_i > 0;
         yneg0_ff  <= y_i[XW-1];
         guard0_ff <= guard_i;
         xu0_ff    <= xu_in;
         rem0_ff   <= rem0_in;
         z0_ff     <= z_i;
      end
   end

   logic                 v_ff     [AFRAC];
   logic                 xpos_ff  [AFRAC];
   logic                 yneg_ff  [AFRAC];
   logic                 guard_ff [AFRAC];
   logic [DIV_W-1:0]     xu_ff    [AFRAC];
   logic [DIV_W-1:0]     rem_ff   [AFRAC];
   logic [AFRAC-1:0]     q_ff     [AFRAC];
   logic signed [ZW-1:0] z_ff     [AFRAC];

   for (genvar i = 0; i < AFRAC; i++) begin : g_bit
      logic                 v_src, xpos_src, yneg_src, guard_src, ge;
      logic [DIV_W-1:0]     xu_src, rem_src, rem_in;
      logic [DIV_W:0]       r2;
      logic [AFRAC-1:0]     q_src;
      logic signed [ZW-1:0] z_src;

      if (i == 0) begin : g_first
         assign v_src     = v0_ff;
         assign xpos_src  = xpos0_ff;
         assign yneg_src  = yneg0_ff;
         assign guard_src = guard0_ff;
         assign xu_src    = xu0_ff;
         assign rem_src   = rem0_ff;
         assign q_src     = '0;
         assign z_src     = z0_ff;
      end else begin : g_next
         assign v_src     = v_ff[i-1];
         assign xpos_src  = xpos_ff[i-1];
         assign yneg_src  = yneg_ff[i-1];
         assign guard_src = guard_ff[i-1];
         assign xu_src    = xu_ff[i-1];
         assign rem_src   = rem_ff[i-1];
         assign q_src     = q_ff[i-1];
         assign z_src     = z_ff[i-1];
      end

      always_comb begin
         r2     = {rem_src, 1'b0};
         ge     = r2 >= {1'b0, xu_src};
         rem_in = ge ? DIV_W'(r2 - {1'b0, xu_src}) : DIV_W'(r2);
      end

      always_ff @(posedge clock) begin
         if (reset) v_ff[i] <= 1'b0;
         else if (en) v_ff[i] <= v_src;
         if (en) begin
            xpos_ff[i]  <= xpos_src;
            yneg_ff[i]  <= yneg_src;
            guard_ff[i] <= guard_src;
            xu_ff[i]    <= xu_src;
            rem_ff[i]   <= rem_in;
            q_ff[i]     <= {q_src[AFRAC-2:0], ge};
            z_ff[i]     <= z_src;
         end
      end
   end

   // add residual, round half up to the output LSB
   logic signed [ZW-1:0] qs, zs, rnd;
   logic [OUT_W-1:0]     angle_in, angle_ff;
   logic                 out_v_ff;

   always_comb begin
      qs = ZW'(q_ff[AFRAC-1]);
      if (!xpos_ff[AFRAC-1]) qs = '0;
      else if (yneg_ff[AFRAC-1]) qs = -qs;
      zs  = z_ff[AFRAC-1] + qs;
      rnd = (zs + HALF) >>> ROUND_SH;
      angle_in = guard_ff[AFRAC-1] ? OUT_W'(rnd) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) out_v_ff <= 1'b0;
      else if (en) out_v_ff <= v_ff[AFRAC-1];
      if (en) angle_ff <= angle_in;
   end

   assign out_valid = out_v_ff;
   assign angle_o   = angle_ff;

endmodule

// ----- rtl/core/aaf_angle.sv -----
// atan2(c, sqrt(a^2 + b^2)): gain scaling of c, two CORDIC vectoring
// passes and the residual divider. Depends on aaf_pkg, aaf_cordic, aaf_recip_div.
module aaf_angle #(
   parameter int STEPS = aaf_pkg::CORDIC_STEPS_DEF,
   parameter int OUT_W = aaf_pkg::ATT_W
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 en,
   input  logic                 in_valid,
   input  aaf_pkg::aaf_vec_type vec_i,
   output logic                 out_valid,
   output logic [OUT_W-1:0]     angle_o
);
   import aaf_pkg::*;

   localparam logic [GAIN_W-1:0] GAIN = GAIN_W'(cordic_gain(STEPS));
   localparam int HI_W = NORM_W - GFRAC;
   localparam int R_W  = HI_W + GAIN_W + 1;

   // scale stage 1: split gain multiply
   logic                        s1_v_ff, s1_cneg_ff, s1_guard_ff;
   logic signed [XW-1:0]        s1_x_ff, s1_y_ff;
   logic [HI_W+GAIN_W-1:0]      phi_ff;
   logic [GFRAC+GAIN_W-1:0]     plo_ff;

   always_ff @(posedge clock) begin
      if (reset) s1_v_ff <= 1'b0;
      else if (en) s1_v_ff <= in_valid;
      if (en) begin
         s1_x_ff     <= XW'(vec_i.a);
         s1_y_ff     <= XW'(vec_i.b);
         phi_ff      <= vec_i.cm[NORM_W-1:GFRAC] * GAIN;
         plo_ff      <= vec_i.cm[GFRAC-1:0] * GAIN;
         s1_cneg_ff  <= vec_i.cneg;
         s1_guard_ff <= vec_i.guard;
      end
   end

   // scale stage 2: combine and restore sign
   logic [R_W-1:0]       r;
   logic signed [XW-1:0] rs, yc_in;
   logic                 s2_v_ff, s2_guard_ff;
   logic signed [XW-1:0] s2_x_ff, s2_y_ff, yc_ff;

   always_comb begin
      r     = R_W'(phi_ff) + R_W'(plo_ff >> GFRAC);
      rs    = XW'(r);
      yc_in = s1_cneg_ff ? -rs : rs;
   end

   always_ff @(posedge clock) begin
      if (reset) s2_v_ff <= 1'b0;
      else if (en) s2_v_ff <= s1_v_ff;
      if (en) begin
         s2_x_ff     <= s1_x_ff;
         s2_y_ff     <= s1_y_ff;
         yc_ff       <= yc_in;
         s2_guard_ff <= s1_guard_ff;
      end
   end

   // pass 1: magnitude of (a, b); scaled c rides along
   logic                 p1_v;
   logic signed [XW-1:0] p1_x;
   logic [XW:0]          p1_pay;

   aaf_cordic #(.STEPS(STEPS), .PAY_W(XW + 1)) u_pass_mag (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (s2_v_ff),
      .x_i      (s2_x_ff),
      .y_i      (s2_y_ff),
      .z_i      ('0),
      .pay_i    ({s2_guard_ff, yc_ff}),
      .out_valid(p1_v),
      .x_o      (p1_x),
      .y_o      (),
      .z_o      (),
      .pay_o    (p1_pay)
   );

   // pass 2: angle of (mag, c)
   logic                 p2_v, p2_guard;
   logic signed [XW-1:0] p2_x, p2_y;
   logic signed [ZW-1:0] p2_z;

   aaf_cordic #(.STEPS(STEPS), .PAY_W(1)) u_pass_ang (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (p1_v),
      .x_i      (p1_x),
      .y_i      (signed'(p1_pay[XW-1:0])),
      .z_i      ('0),
      .pay_i    (p1_pay[XW]),
      .out_valid(p2_v),
      .x_o      (p2_x),
      .y_o      (p2_y),
      .z_o      (p2_z),
      .pay_o    (p2_guard)
   );

   aaf_recip_div #(.OUT_W(OUT_W)) u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (p2_v),
      .x_i      (p2_x),
      .y_i      (p2_y),
      .z_i      (p2_z),
      .guard_i  (p2_guard),
      .out_valid(out_valid),
      .angle_o  (angle_o)
   );

endmodule
